>>> design/hbdec_pkg.sv
// Shared types, constants and microcode for the half-band decimate-by-two core.
// Used by the core and its checker; depends on nothing else.
package hbdec_pkg;

    localparam int SAMPLE_W    = 24;
    localparam int HIST_DEPTH  = 32;
    localparam int ADDR_W      = 5;
    localparam int WORD_W      = 2 * SAMPLE_W;
    localparam int PAIR_W      = SAMPLE_W + 1;
    localparam int COEF_W      = 18;
    localparam int MUL_FULL_W  = PAIR_W + COEF_W;
    localparam int PROD_W      = 42;
    localparam int ACC_W       = 42;
    localparam int SCALE_W     = 58;
    localparam int GAIN_W      = 16;
    localparam int SPLIT_W     = 21;
    localparam int ROUND_SHIFT = 29;
    localparam int RND_W       = SCALE_W - ROUND_SHIFT;
    localparam int FILL_W      = 7;
    localparam int PC_W        = 5;
    localparam int TAP_W       = 4;

    localparam int PACKET_SAMPLES = 126;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;

    localparam int IN_TDATA_W  = 4 * SAMPLE_W;
    localparam int OUT_TDATA_W = 2 * SAMPLE_W;

    localparam logic [PC_W-1:0] STEP_WAIT = 5'd0;
    localparam logic [PC_W-1:0] STEP_OUT  = 5'd19;

    typedef enum logic [2:0] {
        OP_WAIT_IN,
        OP_WR_OLDER,
        OP_READ,
        OP_NOP,
        OP_GAIN_LO,
        OP_GAIN_HI,
        OP_ROUND,
        OP_OUT
    } t_op;

    typedef enum logic [1:0] {
        K_NONE,
        K_TAP,
        K_GAIN_LO,
        K_GAIN_HI
    } t_kind;

    typedef struct packed {
        t_op               op;
        logic [ADDR_W-1:0] off_a;
        logic [ADDR_W-1:0] off_b;
        logic              b_zero;
        logic [TAP_W-1:0]  tap;
        logic [PC_W-1:0]   nxt;
    } t_uword;

    // Folded Q1.17 taps; the last entry is the centre tap (0.5).
    function automatic logic signed [COEF_W-1:0] tap_coef(input logic [TAP_W-1:0] idx);
        logic signed [COEF_W-1:0] c;
        unique case (idx)
            4'd0:    c = -18'sd72;
            4'd1:    c = 18'sd216;
            4'd2:    c = -18'sd539;
            4'd3:    c = 18'sd1150;
            4'd4:    c = -18'sd2275;
            4'd5:    c = 18'sd4500;
            4'd6:    c = -18'sd9977;
            4'd7:    c = 18'sd39765;
            4'd8:    c = 18'sd65536;
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic t_uword uw(input t_op op, input int a, input int b, input logic bz,
                                  input int tap, input logic [PC_W-1:0] nxt);
        t_uword w;
        w.op     = op;
        w.off_a  = ADDR_W'(a);
        w.off_b  = ADDR_W'(b);
        w.b_zero = bz;
        w.tap    = TAP_W'(tap);
        w.nxt    = nxt;
        return w;
    endfunction

    // Control store. Reads issue tap pairs at offsets from the newest slot;
    // the NOP steps let the read/multiply/accumulate pipe drain.
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        unique case (pc)
            5'd0:    w = uw(OP_WAIT_IN,  0,  0, 1'b0, 0, 5'd1);
            5'd1:    w = uw(OP_WR_OLDER, 0,  0, 1'b0, 0, 5'd2);
            5'd2:    w = uw(OP_READ,     0, 30, 1'b0, 0, 5'd3);
            5'd3:    w = uw(OP_READ,     2, 28, 1'b0, 1, 5'd4);
            5'd4:    w = uw(OP_READ,     4, 26, 1'b0, 2, 5'd5);
            5'd5:    w = uw(OP_READ,     6, 24, 1'b0, 3, 5'd6);
            5'd6:    w = uw(OP_READ,     8, 22, 1'b0, 4, 5'd7);
            5'd7:    w = uw(OP_READ,    10, 20, 1'b0, 5, 5'd8);
            5'd8:    w = uw(OP_READ,    12, 18, 1'b0, 6, 5'd9);
            5'd9:    w = uw(OP_READ,    14, 16, 1'b0, 7, 5'd10);
            5'd10:   w = uw(OP_READ,    15,  0, 1'b1, 8, 5'd11);
            5'd11:   w = uw(OP_NOP,      0,  0, 1'b0, 0, 5'd12);
            5'd12:   w = uw(OP_NOP,      0,  0, 1'b0, 0, 5'd13);
            5'd13:   w = uw(OP_NOP,      0,  0, 1'b0, 0, 5'd14);
            5'd14:   w = uw(OP_GAIN_LO,  0,  0, 1'b0, 0, 5'd15);
            5'd15:   w = uw(OP_GAIN_HI,  0,  0, 1'b0, 0, 5'd16);
            5'd16:   w = uw(OP_NOP,      0,  0, 1'b0, 0, 5'd17);
            5'd17:   w = uw(OP_NOP,      0,  0, 1'b0, 0, 5'd18);
            5'd18:   w = uw(OP_ROUND,    0,  0, 1'b0, 0, STEP_OUT);
            5'd19:   w = uw(OP_OUT,      0,  0, 1'b0, 0, STEP_WAIT);
            default: w = uw(OP_NOP,      0,  0, 1'b0, 0, STEP_WAIT);
        endcase
        return w;
    endfunction

endpackage

>>> design/hbdec_ram.sv
// Generic simple dual-read RAM: one write port, two registered read ports.
// Stand-alone; no package needed.
module hbdec_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr0,
    input  logic [AW-1:0]    i_raddr1,
    output logic [WIDTH-1:0] o_rdata0,
    output logic [WIDTH-1:0] o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd0;
    logic [WIDTH-1:0] r_rd1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd0 <= r_mem[i_raddr0];
        r_rd1 <= r_mem[i_raddr1];
    end

    assign o_rdata0 = r_rd0;
    assign o_rdata1 = r_rd1;

endmodule

>>> design/halfband_decimate_by_two_core.sv
// Top level of the 31-tap half-band decimate-by-two filter for one I/Q channel.
// Depends on hbdec_pkg (types, microcode, taps) and hbdec_ram (sample history).

// Each input item carries two consecutive complex samples; the block writes
// both into a 32-entry history and returns one filtered, gain-scaled,
// rounded and saturated I/Q item, so the output rate is half the sample
// rate. An item passes through the program steps from acceptance to its result
// being loaded into the output register, and the block is ready for the next
// item in the cycle after that load. If the result before is still waiting in
// the output register when a new result is ready, the last step holds until
// that item is taken, and the next acceptance moves out with it. The length
// of a pass is set by the history RAM: its two read ports deliver the 17 taps
// of each channel over nine reads, and the shared multiplier then makes two
// more passes to apply the 16-bit gain. The finished result waits in its own
// register, so a new item is taken while the old result is still pending.
// The user must write gain through i_gain_we/i_gain_wdata only while the
// block is idle; the block itself does not enforce this. No clearing pass is
// needed after reset: per-slot valid bits make unwritten history read as zero.
module halfband_decimate_by_two_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_gain_we,
    input  logic [15:0] i_gain_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // i_older [23:0], i_newer [47:24], q_older [71:48], q_newer [95:72]
    input  logic [95:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // filtered_i [23:0], filtered_q [47:24]
    output logic [47:0] m_axis_tdata,
    // packet_end
    output logic        m_axis_tlast
);

    localparam int SW = hbdec_pkg::SAMPLE_W;
    localparam int AW = hbdec_pkg::ADDR_W;
    localparam logic signed [hbdec_pkg::SCALE_W-1:0] ROUND_HALF =
        hbdec_pkg::SCALE_W'(1) << (hbdec_pkg::ROUND_SHIFT - 1);

    // Sequencer.
    logic [hbdec_pkg::PC_W-1:0] r_pc;
    logic [hbdec_pkg::PC_W-1:0] n_pc;
    hbdec_pkg::t_uword          w_cw;
    logic                       w_in_fire;
    logic                       w_out_load;

    // Configuration and history bookkeeping.
    logic [hbdec_pkg::GAIN_W-1:0]   r_gain;
    logic [AW-1:0]                  r_head;
    logic [hbdec_pkg::HIST_DEPTH-1:0] r_valid;
    logic [SW-1:0]                  r_old_i;
    logic [SW-1:0]                  r_old_q;

    // History RAM ports.
    logic                        w_we;
    logic [AW-1:0]               w_waddr;
    logic [hbdec_pkg::WORD_W-1:0] w_wdata;
    logic [AW-1:0]               w_raddr0;
    logic [AW-1:0]               w_raddr1;
    logic [hbdec_pkg::WORD_W-1:0] w_rdata0;
    logic [hbdec_pkg::WORD_W-1:0] w_rdata1;

    // Read stage tags.
    hbdec_pkg::t_kind             r_k1;
    logic [hbdec_pkg::TAP_W-1:0]  r_tap1;
    logic                         r_va1;
    logic                         r_vb1;

    // Operand stage.
    logic signed [SW-1:0]                  w_a_i, w_b_i, w_a_q, w_b_q;
    logic signed [hbdec_pkg::PAIR_W-1:0]   w_pair_i, w_pair_q;
    logic signed [hbdec_pkg::PAIR_W-1:0]   r_opa_i, r_opa_q;
    logic signed [hbdec_pkg::COEF_W-1:0]   r_opb;
    hbdec_pkg::t_kind                      r_k2;

    // Multiply stage.
    logic signed [hbdec_pkg::MUL_FULL_W-1:0] w_full_i, w_full_q;
    logic signed [hbdec_pkg::PROD_W-1:0]     r_prod_i, r_prod_q;
    hbdec_pkg::t_kind                        r_k3;

    // Accumulate, scale and output.
    logic signed [hbdec_pkg::ACC_W-1:0]   r_acc_i, r_acc_q;
    logic signed [hbdec_pkg::SCALE_W-1:0] r_scl_i, r_scl_q;
    logic [SW-1:0]                        r_out_i, r_out_q;
    logic                                 r_out_last;
    logic                                 r_out_valid;
    logic [hbdec_pkg::FILL_W-1:0]         r_fill;
    logic [hbdec_pkg::FILL_W-1:0]         w_fill_inc;
    logic                                 w_last;

    function automatic logic [SW-1:0] sat24(input logic [hbdec_pkg::RND_W-1:0] v);
        logic [hbdec_pkg::RND_W-SW:0] top;
        logic [SW-1:0]               res;
        top = v[hbdec_pkg::RND_W-1:SW-1];
        if ((&top) || !(|top)) begin
            res = v[SW-1:0];
        end else if (v[hbdec_pkg::RND_W-1]) begin
            res = {1'b1, {(SW-1){1'b0}}};
        end else begin
            res = {1'b0, {(SW-1){1'b1}}};
        end
        return res;
    endfunction

    // ---------------------------------------------------------------------
    // Microcode sequencer: the control word of the current step drives the
    // datapath. Waiting steps hold the step counter until their condition.
    // ---------------------------------------------------------------------
    assign w_cw          = hbdec_pkg::ucode(r_pc);
    assign s_axis_tready = (w_cw.op == hbdec_pkg::OP_WAIT_IN);
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;
    assign w_out_load    = (w_cw.op == hbdec_pkg::OP_OUT) && !r_out_valid;

    always_comb begin
        unique case (w_cw.op)
            hbdec_pkg::OP_WAIT_IN: n_pc = w_in_fire  ? w_cw.nxt : r_pc;
            hbdec_pkg::OP_OUT:     n_pc = w_out_load ? w_cw.nxt : r_pc;
            default:               n_pc = w_cw.nxt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= hbdec_pkg::STEP_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= hbdec_pkg::GAIN_RESET;
        end else if (i_gain_we) begin
            r_gain <= i_gain_wdata;
        end
    end

    // ---------------------------------------------------------------------
    // History writes. The newer sample goes in on the acceptance cycle, the
    // older one on the next step, one and two slots below the old head, so
    // the head ends on the older sample, which is the filter's tap zero.
    // ---------------------------------------------------------------------
    assign w_we    = w_in_fire || (w_cw.op == hbdec_pkg::OP_WR_OLDER);
    assign w_waddr = (w_cw.op == hbdec_pkg::OP_WAIT_IN) ? AW'(r_head - AW'(1))
                                                       : AW'(r_head - AW'(2));
    assign w_wdata = (w_cw.op == hbdec_pkg::OP_WAIT_IN)
                   ? {s_axis_tdata[3*SW +: SW], s_axis_tdata[1*SW +: SW]}
                   : {r_old_q, r_old_i};

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_old_i <= s_axis_tdata[0*SW +: SW];
            r_old_q <= s_axis_tdata[2*SW +: SW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_valid <= '0;
        end else begin
            if (w_we) begin
                r_valid[w_waddr] <= 1'b1;
            end
            if (w_cw.op == hbdec_pkg::OP_WR_OLDER) begin
                r_head <= AW'(r_head - AW'(2));
            end
        end
    end

    assign w_raddr0 = AW'(r_head + w_cw.off_a);
    assign w_raddr1 = AW'(r_head + w_cw.off_b);

    hbdec_ram #(
        .WIDTH (hbdec_pkg::WORD_W),
        .DEPTH (hbdec_pkg::HIST_DEPTH)
    ) u_hist (
        .i_clk    (i_clk),
        .i_we     (w_we),
        .i_waddr  (w_waddr),
        .i_wdata  (w_wdata),
        .i_raddr0 (w_raddr0),
        .i_raddr1 (w_raddr1),
        .o_rdata0 (w_rdata0),
        .o_rdata1 (w_rdata1)
    );

    // Read stage: the valid bits and the tap number travel with the RAM read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k1 <= hbdec_pkg::K_NONE;
        end else begin
            r_k1 <= (w_cw.op == hbdec_pkg::OP_READ) ? hbdec_pkg::K_TAP : hbdec_pkg::K_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tap1 <= w_cw.tap;
        r_va1  <= r_valid[w_raddr0];
        r_vb1  <= r_valid[w_raddr1] && !w_cw.b_zero;
    end

    // ---------------------------------------------------------------------
    // Operand stage: either a folded tap pair with its coefficient, or one
    // half of the accumulator with the gain. The accumulator is split into a
    // low unsigned half and a high signed half so one multiplier serves both.
    // ---------------------------------------------------------------------
    assign w_a_i    = r_va1 ? $signed(w_rdata0[SW-1:0])  : '0;
    assign w_a_q    = r_va1 ? $signed(w_rdata0[2*SW-1:SW]) : '0;
    assign w_b_i    = r_vb1 ? $signed(w_rdata1[SW-1:0])  : '0;
    assign w_b_q    = r_vb1 ? $signed(w_rdata1[2*SW-1:SW]) : '0;
    assign w_pair_i = hbdec_pkg::PAIR_W'(w_a_i) + hbdec_pkg::PAIR_W'(w_b_i);
    assign w_pair_q = hbdec_pkg::PAIR_W'(w_a_q) + hbdec_pkg::PAIR_W'(w_b_q);

    always_ff @(posedge i_clk) begin
        if (r_k1 == hbdec_pkg::K_TAP) begin
            r_opa_i <= w_pair_i;
            r_opa_q <= w_pair_q;
            r_opb   <= hbdec_pkg::tap_coef(r_tap1);
        end else if (w_cw.op == hbdec_pkg::OP_GAIN_LO) begin
            r_opa_i <= hbdec_pkg::PAIR_W'(r_acc_i[hbdec_pkg::SPLIT_W-1:0]);
            r_opa_q <= hbdec_pkg::PAIR_W'(r_acc_q[hbdec_pkg::SPLIT_W-1:0]);
            r_opb   <= hbdec_pkg::COEF_W'(r_gain);
        end else if (w_cw.op == hbdec_pkg::OP_GAIN_HI) begin
            r_opa_i <= hbdec_pkg::PAIR_W'(
                           $signed(r_acc_i[hbdec_pkg::ACC_W-1:hbdec_pkg::SPLIT_W]));
            r_opa_q <= hbdec_pkg::PAIR_W'(
                           $signed(r_acc_q[hbdec_pkg::ACC_W-1:hbdec_pkg::SPLIT_W]));
            r_opb   <= hbdec_pkg::COEF_W'(r_gain);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k2 <= hbdec_pkg::K_NONE;
            r_k3 <= hbdec_pkg::K_NONE;
        end else begin
            priority if (r_k1 == hbdec_pkg::K_TAP) begin
                r_k2 <= hbdec_pkg::K_TAP;
            end else if (w_cw.op == hbdec_pkg::OP_GAIN_LO) begin
                r_k2 <= hbdec_pkg::K_GAIN_LO;
            end else if (w_cw.op == hbdec_pkg::OP_GAIN_HI) begin
                r_k2 <= hbdec_pkg::K_GAIN_HI;
            end else begin
                r_k2 <= hbdec_pkg::K_NONE;
            end
            r_k3 <= r_k2;
        end
    end

    // Multiply stage: one 25 x 18 signed product per channel.
    assign w_full_i = hbdec_pkg::MUL_FULL_W'(r_opa_i) * hbdec_pkg::MUL_FULL_W'(r_opb);
    assign w_full_q = hbdec_pkg::MUL_FULL_W'(r_opa_q) * hbdec_pkg::MUL_FULL_W'(r_opb);

    always_ff @(posedge i_clk) begin
        r_prod_i <= w_full_i[hbdec_pkg::PROD_W-1:0];
        r_prod_q <= w_full_q[hbdec_pkg::PROD_W-1:0];
    end

    // ---------------------------------------------------------------------
    // Accumulate and scale. The accumulator is cleared while the older sample
    // is written, before the first product can arrive. The scaled value is
    // low product + (high product << 21); adding half an LSB and shifting
    // right arithmetically rounds to nearest with ties toward plus infinity.
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_cw.op == hbdec_pkg::OP_WR_OLDER) begin
            r_acc_i <= '0;
            r_acc_q <= '0;
        end else if (r_k3 == hbdec_pkg::K_TAP) begin
            r_acc_i <= r_acc_i + hbdec_pkg::ACC_W'(r_prod_i);
            r_acc_q <= r_acc_q + hbdec_pkg::ACC_W'(r_prod_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_k3 == hbdec_pkg::K_GAIN_LO) begin
            r_scl_i <= hbdec_pkg::SCALE_W'(r_prod_i);
            r_scl_q <= hbdec_pkg::SCALE_W'(r_prod_q);
        end else if (r_k3 == hbdec_pkg::K_GAIN_HI) begin
            r_scl_i <= r_scl_i + (hbdec_pkg::SCALE_W'(r_prod_i) <<< hbdec_pkg::SPLIT_W);
            r_scl_q <= r_scl_q + (hbdec_pkg::SCALE_W'(r_prod_q) <<< hbdec_pkg::SPLIT_W);
        end else if (w_cw.op == hbdec_pkg::OP_ROUND) begin
            r_scl_i <= r_scl_i + ROUND_HALF;
            r_scl_q <= r_scl_q + ROUND_HALF;
        end
    end

    // ---------------------------------------------------------------------
    // Output register and packet counter. The result is loaded only into an
    // empty output register; the counter advances once per result.
    // ---------------------------------------------------------------------
    assign w_fill_inc = hbdec_pkg::FILL_W'(r_fill + hbdec_pkg::FILL_W'(1));
    assign w_last     = (w_fill_inc >= hbdec_pkg::FILL_W'(hbdec_pkg::PACKET_SAMPLES));

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_i    <= sat24(r_scl_i[hbdec_pkg::SCALE_W-1:hbdec_pkg::ROUND_SHIFT]);
            r_out_q    <= sat24(r_scl_q[hbdec_pkg::SCALE_W-1:hbdec_pkg::ROUND_SHIFT]);
            r_out_last <= w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_fill      <= '0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
                r_fill      <= w_last ? '0 : w_fill_inc;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_q, r_out_i};
    assign m_axis_tlast  = r_out_last;

endmodule

>>> design/hbdec_chk.sv
// Port-level checker for the half-band decimate-by-two core, bound to its top.
// Depends on hbdec_pkg for the stream widths.
module hbdec_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [hbdec_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                              m_axis_tlast
);

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output item changed");

    // The block works on one item at a time, so it is busy right after taking one.
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken again before the item in work finished");

    // Results are spaced by a full program pass, never back to back.
    a_out_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
        else $error("output item appeared right after a delivered one");

    // Reset leaves the block ready for input with no pending result.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("block not idle after reset");

endmodule

bind halfband_decimate_by_two_core hbdec_chk u_hbdec_chk (.*);
